// File: hdl/slc_pkg.sv
// shared types and constants of the cache tag controller
package slc_pkg;

   localparam int CFG_W      = 4;
   localparam int CSR_IDX_W  = 4;
   localparam int CNT_W      = 32;
   localparam int WAY_OUT_W  = 3;
   localparam int MAX_WAY_W  = 4;
   localparam int MAX_OFFSET = 12;

   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INDEX  = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WAYS   = 4'd2;

   localparam logic [1:0] ACT_WRITE = 2'd1;

   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   typedef enum logic {
      ST_IDLE,
      ST_LOOK
   } slc_state_type;

   typedef struct packed {
      logic                 hit;
      logic                 writeback;
      logic [MAX_WAY_W-1:0] way;
   } slc_outcome_type;

endpackage

// File: hdl/slc_if.sv
// request, response and register write channels of the cache tag controller
interface slc_req_if
   import slc_pkg::*;
#(
   parameter int ADDR_BITS = 32
);
   logic                 valid;
   logic                 ready;
   logic [1:0]           action;
   logic [ADDR_BITS-1:0] address;

   modport source (output valid, action, address, input ready);
   modport sink   (input valid, action, address, output ready);
endinterface

interface slc_rsp_if
   import slc_pkg::*;
;
   logic                 valid;
   logic                 ready;
   logic                 hit;
   logic                 writeback;
   logic [WAY_OUT_W-1:0] way;
   logic [CNT_W-1:0]     access_count;
   logic [CNT_W-1:0]     hit_count;
   logic [CNT_W-1:0]     miss_count;
   logic [CNT_W-1:0]     writeback_count;

   modport source (output valid, hit, writeback, way, access_count, hit_count, miss_count,
                   writeback_count, input ready);
   modport sink   (input valid, hit, writeback, way, access_count, hit_count, miss_count,
                   writeback_count, output ready);
endinterface

interface slc_csr_if
   import slc_pkg::*;
;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CFG_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: hdl/slc_lookup.sv
// hit detection, victim choice and updated set row of one access
module slc_lookup
   import slc_pkg::*;
#(
   parameter int WAYS      = 8,
   parameter int ADDR_BITS = 32,
   parameter int WAY_W     = 3,
   parameter int WCNT_W    = 4
) (
   input  logic [WAYS-1:0][ADDR_BITS-1:0] tags,
   input  logic [WAYS-1:0]                valid,
   input  logic [WAYS-1:0]                dirty,
   input  logic [WAYS-1:0][WAY_W-1:0]     order,
   input  logic [ADDR_BITS-1:0]           tag,
   input  logic                           is_write,
   input  logic [WCNT_W-1:0]              ways_n,
   output slc_outcome_type                outcome,
   output logic [WAYS-1:0][ADDR_BITS-1:0] new_tags,
   output logic [WAYS-1:0]                new_valid,
   output logic [WAYS-1:0]                new_dirty,
   output logic [WAYS-1:0][WAY_W-1:0]     new_order
);

   logic             hit;
   logic [WAY_W-1:0] hit_way;
   logic             found;
   logic [WAY_W-1:0] free_way;
   logic [WAY_W-1:0] lru;
   logic [WAY_W-1:0] way;
   logic [WAY_W-1:0] pos;

   always_comb begin
      hit      = 1'b0;
      hit_way  = '0;
      found    = 1'b0;
      free_way = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (WCNT_W'(w) < ways_n) begin
            if (valid[w] && tags[w] == tag) begin
               hit     = 1'b1;
               hit_way = WAY_W'(w);
            end
            if (!valid[w]) begin
               found    = 1'b1;
               free_way = WAY_W'(w);
            end
         end
      end
   end

   // least recent way in use
   always_comb begin
      lru = '0;
      for (int k = 0; k < WAYS; k++) begin
         if (WCNT_W'(order[k]) < ways_n) begin
            lru = order[k];
         end
      end
   end

   assign way = hit ? hit_way : (found ? free_way : lru);

   always_comb begin
      pos = WAY_W'(WAYS - 1);
      for (int p = WAYS - 1; p >= 0; p--) begin
         if (order[p] == way) begin
            pos = WAY_W'(p);
         end
      end
   end

   always_comb begin
      new_order[0] = way;
      for (int p = 1; p < WAYS; p++) begin
         new_order[p] = (WAY_W'(p) <= pos) ? order[p-1] : order[p];
      end
   end

   always_comb begin
      new_tags  = tags;
      new_valid = valid;
      new_dirty = dirty;
      if (hit) begin
         new_dirty[way] = dirty[way] | is_write;
      end else begin
         new_tags[way]  = tag;
         new_valid[way] = 1'b1;
         new_dirty[way] = is_write;
      end
   end

   assign outcome.hit       = hit;
   assign outcome.writeback = !hit && !found && dirty[lru];
   assign outcome.way       = MAX_WAY_W'(way);

endmodule

// File: hdl/set_assoc_lru_cache_tags.sv
// top level of the set-associative write-back cache tag, state and lru controller
//
// req_ch carries one access a beat (action, address); rsp_ch returns one beat per
// access with hit, writeback, way and the four saturating statistics counters.
// csr_ch writes offset_bits, index_bits and ways_in_use and is always ready; the user
// must write it only while no access is in flight, the block does not enforce it.
// each set lives in one row of a single-port synchronous memory: tags, valid,
// dirty and the recency order of all ways. an accepted access reads its row into
// a register; in the lookup state the block compares, picks the victim and writes
// the row back once the response register is free, and registers the response.
// a new access is taken only after the row write, as the read and the write of
// the set row share the one memory port.
// reset clears the counters and a per-set row-valid flop array and loads the
// default configuration; a set never written reads as all invalid, clean, with way
// 0 most recent. no clearing pass is needed, so requests are taken right after reset.
// a stalled response holds in its output register; the next request is still
// taken, and its update waits until the response register is free.
module set_assoc_lru_cache_tags
   import slc_pkg::*;
#(
   parameter int SETS      = 256,
   parameter int WAYS      = 8,
   parameter int ADDR_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   slc_req_if.sink     req_ch,
   slc_rsp_if.source   rsp_ch,
   slc_csr_if.sink     csr_ch
);

   localparam int SET_W   = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int IDX_MAX = $clog2(SETS + 1) - 1;
   localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int WCNT_W  = WAY_W + 1;
   localparam int TAGS_W  = WAYS * ADDR_BITS;
   localparam int ORDER_W = WAYS * WAY_W;
   localparam int ROW_W   = TAGS_W + 2 * WAYS + ORDER_W;
   localparam int SH_W    = 5;

   slc_state_type state_ff, state_in;

   logic [CFG_W-1:0] cfg_offset_ff, cfg_index_ff, cfg_ways_ff;

   logic [ROW_W-1:0] mem [SETS];
   logic [ROW_W-1:0] rd_row_ff;
   logic [SETS-1:0]  row_ok_ff;
   logic             row_ok_q_ff;

   logic [SET_W-1:0]     set_ff;
   logic [ADDR_BITS-1:0] tag_ff;
   logic                 is_write_ff;

   logic [CFG_W-1:0]     ob, ib;
   logic [SH_W-1:0]      sh;
   logic [SET_W-1:0]     set_mask;
   logic [ADDR_BITS-1:0] addr_sh;
   logic [SET_W-1:0]     set_in;
   logic [ADDR_BITS-1:0] tag_in;
   logic [WCNT_W-1:0]    ways_n;
   logic [4:0]           ways_cfg;

   logic req_take, look_done, out_free;

   logic [WAYS-1:0][ADDR_BITS-1:0] rd_tags, new_tags;
   logic [WAYS-1:0]                rd_valid, rd_dirty, new_valid, new_dirty;
   logic [WAYS-1:0][WAY_W-1:0]     rd_order, new_order;
   slc_outcome_type                outcome;

   logic                 rsp_valid_ff;
   logic                 hit_ff, writeback_ff;
   logic [WAY_OUT_W-1:0] way_ff;
   logic [CNT_W-1:0]     access_ff, hits_ff, misses_ff, wbs_ff;

   // configuration decode
   assign ob = (cfg_offset_ff > CFG_W'(MAX_OFFSET)) ? CFG_W'(MAX_OFFSET) : cfg_offset_ff;
   assign ib = (cfg_index_ff > CFG_W'(IDX_MAX)) ? CFG_W'(IDX_MAX) : cfg_index_ff;
   assign sh = SH_W'(ob) + SH_W'(ib);

   always_comb begin
      if (cfg_ways_ff == '0) begin
         ways_cfg = 5'd1;
      end else if ({1'b0, cfg_ways_ff} > 5'(WAYS)) begin
         ways_cfg = 5'(WAYS);
      end else begin
         ways_cfg = {1'b0, cfg_ways_ff};
      end
   end
   assign ways_n = WCNT_W'(ways_cfg);

   // address split
   assign addr_sh  = req_ch.address >> ob;
   assign set_mask = ~({SET_W{1'b1}} << ib);
   assign set_in   = addr_sh[SET_W-1:0] & set_mask;
   assign tag_in   = (7'(sh) >= 7'(ADDR_BITS)) ? '0 : (req_ch.address >> sh);

   // state machine
   assign out_free  = !rsp_valid_ff || rsp_ch.ready;
   assign req_take  = req_ch.valid && req_ch.ready;
   assign look_done = (state_ff == ST_LOOK) && out_free;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      case (state_ff)
         ST_IDLE: req_ch.ready = 1'b1;
         ST_LOOK: req_ch.ready = 1'b0;
         default: req_ch.ready = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // configuration registers
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_offset_ff <= CFG_W'(6);
         cfg_index_ff  <= CFG_W'(8);
         cfg_ways_ff   <= CFG_W'(8);
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_OFFSET: cfg_offset_ff <= csr_ch.data;
            CSR_INDEX:  cfg_index_ff  <= csr_ch.data;
            CSR_WAYS:   cfg_ways_ff   <= csr_ch.data;
            default: ;
         endcase
      end
   end

   // access capture
   always_ff @(posedge clock) begin
      if (req_take) begin
         set_ff      <= set_in;
         tag_ff      <= tag_in;
         is_write_ff <= (req_ch.action == ACT_WRITE);
      end
   end

   // set row memory
   always_ff @(posedge clock) begin
      if (req_take) begin
         rd_row_ff <= mem[set_in];
      end
      if (look_done) begin
         mem[set_ff] <= {new_order, new_dirty, new_valid, new_tags};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ok_ff   <= '0;
         row_ok_q_ff <= 1'b0;
      end else begin
         if (req_take) begin
            row_ok_q_ff <= row_ok_ff[set_in];
         end
         if (look_done) begin
            row_ok_ff[set_ff] <= 1'b1;
         end
      end
   end

   // row unpack, untouched sets read as reset state
   always_comb begin
      rd_tags = rd_row_ff[TAGS_W-1:0];
      if (row_ok_q_ff) begin
         rd_valid = rd_row_ff[TAGS_W +: WAYS];
         rd_dirty = rd_row_ff[TAGS_W + WAYS +: WAYS];
         rd_order = rd_row_ff[TAGS_W + 2 * WAYS +: ORDER_W];
      end else begin
         rd_valid = '0;
         rd_dirty = '0;
         for (int k = 0; k < WAYS; k++) begin
            rd_order[k] = WAY_W'(k);
         end
      end
   end

   slc_lookup #(
      .WAYS      (WAYS),
      .ADDR_BITS (ADDR_BITS),
      .WAY_W     (WAY_W),
      .WCNT_W    (WCNT_W)
   ) u_lookup (
      .tags      (rd_tags),
      .valid     (rd_valid),
      .dirty     (rd_dirty),
      .order     (rd_order),
      .tag       (tag_ff),
      .is_write  (is_write_ff),
      .ways_n    (ways_n),
      .outcome   (outcome),
      .new_tags  (new_tags),
      .new_valid (new_valid),
      .new_dirty (new_dirty),
      .new_order (new_order)
   );

   // counters and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         access_ff    <= '0;
         hits_ff      <= '0;
         misses_ff    <= '0;
         wbs_ff       <= '0;
      end else begin
         if (look_done) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (look_done) begin
            if (access_ff != CNT_MAX) begin
               access_ff <= access_ff + 1'b1;
            end
            if (outcome.hit && hits_ff != CNT_MAX) begin
               hits_ff <= hits_ff + 1'b1;
            end
            if (!outcome.hit && misses_ff != CNT_MAX) begin
               misses_ff <= misses_ff + 1'b1;
            end
            if (outcome.writeback && wbs_ff != CNT_MAX) begin
               wbs_ff <= wbs_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (look_done) begin
         hit_ff       <= outcome.hit;
         writeback_ff <= outcome.writeback;
         way_ff       <= outcome.way[WAY_OUT_W-1:0];
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.hit             = hit_ff;
   assign rsp_ch.writeback       = writeback_ff;
   assign rsp_ch.way             = way_ff;
   assign rsp_ch.access_count    = access_ff;
   assign rsp_ch.hit_count       = hits_ff;
   assign rsp_ch.miss_count      = misses_ff;
   assign rsp_ch.writeback_count = wbs_ff;

`ifndef SYNTHESIS
   a_take_then_look: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == ST_LOOK) && !req_ch.ready)
      else $error("accepted access did not enter lookup");

   a_rsp_from_look: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_LOOK))
      else $error("response raised without a lookup");

   a_count_balance: assert property (@(posedge clock) disable iff (reset)
      (access_ff != CNT_MAX) |-> ({1'b0, access_ff} == {1'b0, hits_ff} + {1'b0, misses_ff}))
      else $error("hit and miss counts do not add up to accesses");

   a_wb_le_miss: assert property (@(posedge clock) disable iff (reset)
      wbs_ff <= misses_ff)
      else $error("more writebacks than misses");
`endif

endmodule
